### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // window fill count and result count widths
  localparam int unsigned FillW    = 4;
  localparam int unsigned ResCntW  = 4;
  // most results one transaction can cause
  localparam int unsigned ResDepth = 8;
  // configuration port
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned MaxRepl  = 8;

  // register indexes, at paddr[4:3]
  localparam logic [1:0] RegPatBytes = 2'd0;
  localparam logic [1:0] RegPatLen   = 2'd1;
  localparam logic [1:0] RegRepBytes = 2'd2;
  localparam logic [1:0] RegRepLen   = 2'd3;

  // one output character with its end marker
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } res_t;

  // per-cell control from the window controller
  typedef struct packed {
    logic write;       // append the new character at the fill position
    logic shift;       // drop the oldest character, append the new one
    logic at_fill;     // this cell is the next free slot
    logic below_fill;  // this cell holds a buffered character
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window slot: holds a character, takes its right neighbor's character
// on a shift, and compares its slot against the matching pattern byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfr_cell (
  input  logic               clk_i,
  input  sfr_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]         in_char_i,
  input  logic [7:0]         nbr_char_i,
  input  logic               nbr_below_i,
  input  logic [7:0]         pat_char_i,
  output logic [7:0]         char_o,
  output logic               below_o,
  output logic               match_o
);
  import sfr_pkg::*;

  logic [7:0] char_q;
  logic [7:0] char_d;

  // next slot content
  always_comb begin
    char_d = char_q;
    if (ctrl_i.write && ctrl_i.at_fill) begin
      char_d = in_char_i;
    end else if (ctrl_i.shift && ctrl_i.below_fill) begin
      if (nbr_below_i) begin
        char_d = nbr_char_i;
      end else begin
        char_d = in_char_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  // slot compare: held character, incoming character, or unused slot
  always_comb begin
    if (ctrl_i.below_fill) begin
      match_o = (char_q == pat_char_i);
    end else if (ctrl_i.at_fill) begin
      match_o = (in_char_i == pat_char_i);
    end else begin
      match_o = 1'b1;
    end
  end

  assign char_o  = char_q;
  assign below_o = ctrl_i.below_fill;

endmodule

`default_nettype wire

### rtl/sfr_emit.sv
// ----------------------------------------------------------------------------
// sfr_emit
// Result queue and output register: takes the results of one transaction at
// once and hands them out one per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfr_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  sfr_pkg::res_t                res_i [sfr_pkg::ResDepth],
  input  logic [sfr_pkg::ResCntW-1:0]  res_cnt_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_char_o,
  output logic                         is_last_o,
  output logic                         busy_o
);
  import sfr_pkg::*;

  res_t               pend_q [ResDepth];
  logic [ResCntW-1:0] pcnt_q;
  res_t               out_q;
  logic               out_valid_q;
  logic               out_load;

  assign out_load = !out_valid_q || !out_stall_i;

  // control: counts and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (pcnt_q != '0) begin
      if (out_load) begin
        pcnt_q      <= pcnt_q - ResCntW'(1);
        out_valid_q <= 1'b1;
      end
    end else if (load_i && (res_cnt_i != '0)) begin
      if (out_load) begin
        pcnt_q      <= res_cnt_i - ResCntW'(1);
        out_valid_q <= 1'b1;
      end else begin
        pcnt_q <= res_cnt_i;
      end
    end else if (out_load) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: queue shifts toward the head at index 0
  always_ff @(posedge clk_i) begin
    if (pcnt_q != '0) begin
      if (out_load) begin
        out_q <= pend_q[0];
        for (int k = 0; k < ResDepth - 1; k++) begin
          pend_q[k] <= pend_q[k+1];
        end
      end
    end else if (load_i && (res_cnt_i != '0)) begin
      if (out_load) begin
        out_q <= res_i[0];
        for (int k = 0; k < ResDepth - 1; k++) begin
          pend_q[k] <= res_i[k+1];
        end
      end else begin
        for (int k = 0; k < ResDepth; k++) begin
          pend_q[k] <= res_i[k];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_q.ch;
  assign is_last_o   = out_q.last;
  assign busy_o      = (pcnt_q != '0);

endmodule

`default_nettype wire

### rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a character stream, one window slot per
// cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one character per
//   transaction, or a terminator with is_end_i high. Output channel
//   (out_valid_o / out_stall_i) gives one character per transaction; the
//   zero byte with is_last_o high closes each string.
//   A transaction's first result is registered. Throughput is one character
//   per cycle while each character causes at most one result and the
//   receiver does not stall. A transaction causing N results (a
//   replacement, or the window flush at a terminator, N up to 8) holds
//   in_stall_o high while the result queue drains; this queue is the limit.
//   When the receiver stalls, the output register holds its result and the
//   queue fills; the input is stalled while the queue is not empty.
//   Reset empties the window and queue, sets pattern length to 1 and clears
//   the other registers. Configuration (APB, 64-bit registers at 8*i) is
//   to be written by the user while the block is idle, which the block
//   does not enforce; writing pattern_length empties the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stream_find_replace #(
  parameter int unsigned MaxPattern = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::AddrW-1:0]   paddr,
  input  logic [sfr_pkg::DataW-1:0]   pwdata,
  output logic [sfr_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_char_i,
  input  logic                        is_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_char_o,
  output logic                        is_last_o
);
  import sfr_pkg::*;

  logic [DataW-1:0] pat_q;
  logic [LenW-1:0]  plen_q;
  logic [DataW-1:0] rep_q;
  logic [LenW-1:0]  rlen_q;
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] fill_d;

  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             acc;
  logic [FillW-1:0] plen_eff;
  logic [ResCntW-1:0] rlen_eff;
  logic             full;
  logic             match;
  logic             busy;

  cell_ctrl_t       ctrl [MaxPattern];
  logic [7:0]       cell_char [MaxPattern];
  logic             cell_below [MaxPattern];
  logic             cell_match [MaxPattern];
  logic [MaxPattern-1:0] match_vec;
  logic [7:0]       win_ext [ResDepth];

  res_t               res [ResDepth];
  logic [ResCntW-1:0] res_cnt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:AddrW-2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= LenW'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegPatBytes: pat_q  <= pwdata;
        RegPatLen:   plen_q <= pwdata[LenW-1:0];
        RegRepBytes: rep_q  <= pwdata;
        RegRepLen:   rlen_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegPatBytes: prdata = pat_q;
      RegPatLen:   prdata = DataW'(plen_q);
      RegRepBytes: prdata = rep_q;
      RegRepLen:   prdata = DataW'(rlen_q);
      default:     prdata = '0;
    endcase
  end

  // effective lengths
  always_comb begin
    if (plen_q == '0) begin
      plen_eff = FillW'(1);
    end else if (FillW'(plen_q) > FillW'(MaxPattern)) begin
      plen_eff = FillW'(MaxPattern);
    end else begin
      plen_eff = FillW'(plen_q);
    end
    if (ResCntW'(rlen_q) > ResCntW'(MaxRepl)) begin
      rlen_eff = ResCntW'(MaxRepl);
    end else begin
      rlen_eff = ResCntW'(rlen_q);
    end
  end

  assign acc  = in_valid_i && !in_stall_o;
  assign full = (FillW'(fill_q + FillW'(1)) == plen_eff);

  // window cells
  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    assign ctrl[k].write      = acc && !is_end_i && !full;
    assign ctrl[k].shift      = acc && !is_end_i && full && !match;
    assign ctrl[k].at_fill    = (fill_q == FillW'(k));
    assign ctrl[k].below_fill = (FillW'(k) < fill_q);

    if (k < MaxPattern - 1) begin : g_mid
      sfr_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl[k]),
        .in_char_i   (in_char_i),
        .nbr_char_i  (cell_char[k+1]),
        .nbr_below_i (cell_below[k+1]),
        .pat_char_i  (pat_q[8*k +: 8]),
        .char_o      (cell_char[k]),
        .below_o     (cell_below[k]),
        .match_o     (cell_match[k])
      );
    end else begin : g_end
      sfr_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl[k]),
        .in_char_i   (in_char_i),
        .nbr_char_i  (8'h00),
        .nbr_below_i (1'b0),
        .pat_char_i  (pat_q[8*k +: 8]),
        .char_o      (cell_char[k]),
        .below_o     (cell_below[k]),
        .match_o     (cell_match[k])
      );
    end
    assign match_vec[k] = cell_match[k];
  end

  assign match = &match_vec;

  // window contents padded to the result depth
  for (genvar k = 0; k < ResDepth; k++) begin : g_win
    if (k < MaxPattern) begin : g_held
      assign win_ext[k] = cell_char[k];
    end else begin : g_pad
      assign win_ext[k] = 8'h00;
    end
  end

  // results of the accepted transaction and next fill count
  always_comb begin
    for (int k = 0; k < ResDepth; k++) begin
      res[k] = '{ch: 8'h00, last: 1'b0};
    end
    res_cnt = '0;
    fill_d  = fill_q;
    if (acc) begin
      if (is_end_i) begin
        for (int k = 0; k < ResDepth; k++) begin
          if (FillW'(k) < fill_q) begin
            res[k].ch = win_ext[k];
          end
          if (FillW'(k) == fill_q) begin
            res[k].last = 1'b1;
          end
        end
        res_cnt = ResCntW'(fill_q) + ResCntW'(1);
        fill_d  = '0;
      end else if (full) begin
        if (match) begin
          for (int k = 0; k < ResDepth; k++) begin
            res[k].ch = rep_q[8*k +: 8];
          end
          res_cnt = rlen_eff;
          fill_d  = '0;
        end else begin
          res[0].ch = (fill_q == '0) ? in_char_i : win_ext[0];
          res_cnt   = ResCntW'(1);
        end
      end else begin
        fill_d = FillW'(fill_q + FillW'(1));
      end
    end
    if (cfg_wr && (cfg_idx == RegPatLen)) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // result queue and output register
  sfr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc),
    .res_i       (res),
    .res_cnt_i   (res_cnt),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .is_last_o   (is_last_o),
    .busy_o      (busy)
  );

  assign in_stall_o = busy;

  // window never holds a full pattern between transactions
  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < plen_eff)
    else $error("window fill reached pattern length");

  // a terminator always leaves a result in the output register
  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_end_i |=> out_valid_o)
    else $error("terminator produced no output");

  // queued results imply the output register is occupied
  a_queue_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("result queue not empty while output register empty");

endmodule

`default_nettype wire
